// ===== design/aai_pkg.sv =====
// ----------------------------------------------------------------------------
// aai_pkg: shared types and constants for the immediate ALU
// Item layouts for the request and response channels, group and opcode codes.
// ----------------------------------------------------------------------------
package aai_pkg;

    localparam int unsigned REG_COUNT = 31;
    localparam int unsigned REG_W     = 64;
    localparam int unsigned LOW_W     = 32;
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned IMM12_W   = 12;
    localparam int unsigned SHIFT12   = 12;

    localparam logic [4:0] ZR_IDX = 5'd31;

    // instruction groups
    localparam logic [2:0] GRP_ARITH = 3'd2;
    localparam logic [2:0] GRP_MOVE  = 3'd5;

    // arithmetic opcodes
    localparam logic [1:0] OPC_ADD  = 2'd0;
    localparam logic [1:0] OPC_ADDS = 2'd1;
    localparam logic [1:0] OPC_SUB  = 2'd2;
    localparam logic [1:0] OPC_SUBS = 2'd3;

    // wide move opcodes
    localparam logic [1:0] OPC_MOVN = 2'd0;
    localparam logic [1:0] OPC_MOVX = 2'd1;
    localparam logic [1:0] OPC_MOVZ = 2'd2;
    localparam logic [1:0] OPC_MOVK = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        size_64;
        logic [1:0]  opc;
        logic [17:0] operand;
        logic [4:0]  dest_reg;
    } req_t;

    typedef struct packed {
        logic        status;
        logic        wrote;
        logic [4:0]  written_reg;
        logic [63:0] written_value;
        logic [3:0]  flags_nzcv;
    } rsp_t;

endpackage

// ===== design/aai_stream_if.sv =====
// ----------------------------------------------------------------------------
// aai_stream_if: valid/ready channel carrying one item per handshake
// The payload type is set per instance.
// ----------------------------------------------------------------------------
interface aai_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ===== design/aarch64_immediate_alu.sv =====
// ----------------------------------------------------------------------------
// aarch64_immediate_alu: AArch64 data-processing-immediate execute unit
// An accepted item waits in the input register, then goes through one pass of
// logic into the result register. Throughput: one item per cycle unless the
// response channel stalls; the single 64-bit adder path sets the pace.
// Reset clears the register file, the NZCV flags and both valid flags.
// ----------------------------------------------------------------------------
module aarch64_immediate_alu (
    input  logic                clk,
    input  logic                rst_n,
    aai_stream_if.sink          req,
    aai_stream_if.source        rsp
);
    import aai_pkg::*;

    // ------------------------------------------------------------------
    // Pipeline registers and architectural state
    // ------------------------------------------------------------------
    req_t             in_reg;
    logic             in_valid_reg;
    rsp_t             out_reg;
    logic             out_valid_reg;
    logic [REG_W-1:0] rf_reg [REG_COUNT];
    logic [3:0]       flags_reg;

    logic             out_free;
    logic             exec_fire;

    // Result register frees up when empty or being taken this cycle.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign exec_fire = in_valid_reg && out_free;

    // Input register takes a new item whenever its current one moves on.
    assign req.ready = !in_valid_reg || exec_fire;

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    logic              is_arith;
    logic              is_move;
    logic [4:0]        rd;
    logic [4:0]        rn;
    logic              wide;
    logic [4:0]        rd_addr;
    logic [REG_W-1:0]  rdata;

    assign wide     = in_reg.size_64;
    assign rd       = in_reg.dest_reg;
    assign rn       = in_reg.operand[4:0];
    assign is_arith = (in_reg.req_type == GRP_ARITH);
    assign is_move  = (in_reg.req_type == GRP_MOVE) && (in_reg.opc != OPC_MOVX);

    // One read port: arithmetic reads rn, MOVK reads rd. Register 31 reads zero.
    assign rd_addr = is_arith ? rn : rd;
    assign rdata   = (rd_addr == ZR_IDX) ? '0 : rf_reg[rd_addr];

    // ------------------------------------------------------------------
    // Add/subtract immediate, flags at 32 or 64 bits
    // ------------------------------------------------------------------
    logic [IMM12_W-1:0] imm12;
    logic [REG_W-1:0]   arith_imm;
    logic               is_add;
    logic [REG_W-1:0]   b_eff;
    logic               cin;
    logic [LOW_W:0]     sum_lo;
    logic [LOW_W:0]     sum_hi;
    logic [REG_W-1:0]   arith_sum;
    logic [3:0]         nzcv32;
    logic [3:0]         nzcv64;
    logic [REG_W-1:0]   arith_res;
    logic               arith_ok;

    assign imm12     = in_reg.operand[16:5];
    assign arith_imm = in_reg.operand[17]
                     ? {{(REG_W-IMM12_W-SHIFT12){1'b0}}, imm12, {SHIFT12{1'b0}}}
                     : {{(REG_W-IMM12_W){1'b0}}, imm12};
    assign is_add    = !in_reg.opc[1];

    // Subtract as a + ~b + 1 so the carry out is the ARM "no borrow" flag.
    assign b_eff  = is_add ? arith_imm : ~arith_imm;
    assign cin    = !is_add;
    assign sum_lo = {1'b0, rdata[LOW_W-1:0]} + {1'b0, b_eff[LOW_W-1:0]}
                  + {{LOW_W{1'b0}}, cin};
    assign sum_hi = {1'b0, rdata[REG_W-1:LOW_W]} + {1'b0, b_eff[REG_W-1:LOW_W]}
                  + {{LOW_W{1'b0}}, sum_lo[LOW_W]};
    assign arith_sum = {sum_hi[LOW_W-1:0], sum_lo[LOW_W-1:0]};

    // Overflow: operands agree in sign and the result does not.
    assign nzcv32 = {arith_sum[LOW_W-1],
                     (arith_sum[LOW_W-1:0] == '0),
                     sum_lo[LOW_W],
                     (rdata[LOW_W-1] == b_eff[LOW_W-1])
                         && (arith_sum[LOW_W-1] != rdata[LOW_W-1])};
    assign nzcv64 = {arith_sum[REG_W-1],
                     (arith_sum == '0),
                     sum_hi[LOW_W],
                     (rdata[REG_W-1] == b_eff[REG_W-1])
                         && (arith_sum[REG_W-1] != rdata[REG_W-1])};

    assign arith_res = wide ? arith_sum : {{LOW_W{1'b0}}, arith_sum[LOW_W-1:0]};

    // rd or rn of 31 names the stack pointer, which is absent: skip quietly.
    assign arith_ok = is_arith && (rd != ZR_IDX) && (rn != ZR_IDX);

    // ------------------------------------------------------------------
    // Wide moves on 16-bit halfwords
    // ------------------------------------------------------------------
    logic [5:0]       hw_shift;
    logic [REG_W-1:0] move_imm;
    logic [REG_W-1:0] move_mask;
    logic [REG_W-1:0] move_raw;
    logic [REG_W-1:0] move_res;

    assign hw_shift  = {in_reg.operand[17:16], 4'b0000};
    assign move_mask = {{(REG_W-HALF_W){1'b0}}, {HALF_W{1'b1}}} << hw_shift;

    always_comb
    begin
        move_imm = {{(REG_W-HALF_W){1'b0}}, in_reg.operand[HALF_W-1:0]} << hw_shift;
        // In 32-bit mode a halfword shifted past bit 31 drops to zero.
        if (!wide)
        begin
            move_imm[REG_W-1:LOW_W] = '0;
        end
        case (in_reg.opc)
            OPC_MOVN: move_raw = ~move_imm;
            OPC_MOVZ: move_raw = move_imm;
            OPC_MOVK: move_raw = (rdata & ~move_mask) | move_imm;
            default:  move_raw = '0;
        endcase
        move_res = wide ? move_raw : {{LOW_W{1'b0}}, move_raw[LOW_W-1:0]};
    end

    // ------------------------------------------------------------------
    // Result and state updates
    // ------------------------------------------------------------------
    logic             wr_en;
    logic [REG_W-1:0] wr_data;
    logic             flag_set;
    logic [3:0]       flags_next;
    rsp_t             out_next;

    assign wr_en    = arith_ok || (is_move && (rd != ZR_IDX));
    assign wr_data  = is_arith ? arith_res : move_res;
    assign flag_set = arith_ok && in_reg.opc[0];

    always_comb
    begin
        flags_next = flags_reg;
        if (flag_set)
        begin
            flags_next = wide ? nzcv64 : nzcv32;
        end
        out_next.status        = !(is_arith || is_move);
        out_next.wrote         = wr_en;
        out_next.written_reg   = wr_en ? rd : '0;
        out_next.written_value = wr_en ? wr_data : '0;
        out_next.flags_nzcv    = flags_next;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg <= req.payload;
        end
    end

    // Result register: load on execute, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= exec_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_reg <= out_next;
        end
    end

    // Register file and flags advance in item order, one item per cycle while the
    // result register is free, so the next item always reads fully updated state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
            flags_reg <= '0;
        end
        else if (exec_fire)
        begin
            if (wr_en)
            begin
                rf_reg[rd] <= wr_data;
            end
            flags_reg <= flags_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A waiting item is never dropped from the input register.
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !exec_fire |=> in_valid_reg)
        else $error("input item lost while stalled");

    // No execution while a result is stuck in the output register.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |-> !exec_fire)
        else $error("result register overwritten");

    // Flags change only for ADDS and SUBS that actually execute.
    a_flags_stable: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && !flag_set |=> $stable(flags_reg))
        else $error("flags changed without a flag-setting item");

    // 32-bit operations leave the upper half of the result clear.
    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && !wide |=> out_reg.written_value[REG_W-1:LOW_W] == '0)
        else $error("32-bit result has upper bits set");

    // Invalid items never write a register.
    a_invalid_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && !is_arith && !is_move |-> !wr_en)
        else $error("invalid item wrote a register");
`endif

endmodule

// ===== tb/sv/tb_aarch64_immediate_alu.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aarch64_immediate_alu: self-checking bench for the immediate ALU
// Drives AArch64 add/sub-immediate and wide-move items into the request
// channel and checks every result item against a cycle-free model of the
// register file and NZCV flags. Starts with a directed table of corner cases
// (zero register, invalid groups, carry, zero and overflow at both widths),
// then runs random instruction streams under varying back-pressure.
// ----------------------------------------------------------------------------
module tb_aarch64_immediate_alu;

    import aai_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 8;

    // one instruction with an optional hand-typed result
    typedef struct {
        req_t rq;
        bit   known;
        rsp_t rsp;
    } insn_row_t;

    logic clk;
    logic rst_n;

    aai_stream_if #(.payload_t(req_t)) req_if ();
    aai_stream_if #(.payload_t(rsp_t)) rsp_if ();

    aarch64_immediate_alu u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // ------------------------------------------------------------------
    // Architectural state mirror: x0..x30 and NZCV
    // ------------------------------------------------------------------
    logic [63:0] gpr [0:REG_COUNT-1];
    logic [3:0]  nzcv;

    insn_row_t   directed_rows[$];
    insn_row_t   typed_results[$];   // one entry per item offered, in order
    rsp_t        pending_results[$]; // one entry per item accepted

    int unsigned errors;
    int unsigned items_in;
    int unsigned results_out;
    int unsigned n_arith;
    int unsigned n_move;
    int unsigned n_invalid;
    int unsigned n_writes;
    int unsigned cycles;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit          long_hold_pending;

    // ------------------------------------------------------------------
    // Clock and cycle budget
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still due",
                     $time, cycles, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Flag computation: NZCV of a + b or a - b at 32 or 64 bits
    // ------------------------------------------------------------------
    function automatic logic [3:0] nzcv_of(logic [63:0] a, logic [63:0] b,
                                           logic wide, logic add);
        logic [63:0] msk;
        logic [63:0] sbit;
        logic [63:0] r;
        logic        c;
        logic        v;
        msk  = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        sbit = wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
        a    = a & msk;
        b    = b & msk;
        if (add) begin
            r = (a + b) & msk;
            c = (r < a);            // wrapped means carry out
            v = |(~(a ^ b) & (a ^ r) & sbit);
        end
        else begin
            r = (a - b) & msk;
            c = (a >= b);           // no borrow
            v = |((a ^ b) & (a ^ r) & sbit);
        end
        return {|(r & sbit), (r == 64'd0), c, v};
    endfunction

    // ------------------------------------------------------------------
    // Execute one instruction on the mirror state and return its result
    // ------------------------------------------------------------------
    function automatic rsp_t execute_insn(req_t rq);
        rsp_t        rs;
        logic [4:0]  rn;
        logic [63:0] imm;
        logic [63:0] a;
        logic [63:0] r;
        logic        add;
        int unsigned sh;
        rs = '0;
        if (rq.req_type == GRP_ARITH) begin
            rn  = rq.operand[4:0];
            imm = {52'd0, rq.operand[16:5]};
            if (rq.operand[17])
                imm = imm << SHIFT12;
            // rd or rn of 31 names SP: skip quietly, state untouched
            if (rq.dest_reg != ZR_IDX && rn != ZR_IDX) begin
                a   = gpr[rn];
                add = (rq.opc == OPC_ADD || rq.opc == OPC_ADDS);
                r   = add ? a + imm : a - imm;
                if (rq.opc == OPC_ADDS || rq.opc == OPC_SUBS)
                    nzcv = nzcv_of(a, imm, rq.size_64, add);
                if (!rq.size_64)
                    r[63:32] = '0;
                gpr[rq.dest_reg] = r;
                rs.wrote         = 1'b1;
                rs.written_reg   = rq.dest_reg;
                rs.written_value = r;
            end
        end
        else if (rq.req_type == GRP_MOVE && rq.opc != OPC_MOVX) begin
            sh  = 16 * rq.operand[17:16];
            imm = {48'd0, rq.operand[15:0]} << sh;
            if (!rq.size_64)
                imm[63:32] = '0;    // hw 2/3 collapses to zero at 32 bits
            case (rq.opc)
                OPC_MOVN: r = ~imm;
                OPC_MOVZ: r = imm;
                default: begin
                    a = (rq.dest_reg == ZR_IDX) ? 64'd0 : gpr[rq.dest_reg];
                    r = (a & ~(64'hFFFF << sh)) | imm;
                end
            endcase
            if (!rq.size_64)
                r[63:32] = '0;
            // XZR target: value computed, then dropped
            if (rq.dest_reg != ZR_IDX) begin
                gpr[rq.dest_reg] = r;
                rs.wrote         = 1'b1;
                rs.written_reg   = rq.dest_reg;
                rs.written_value = r;
            end
        end
        else begin
            rs.status = 1'b1;
        end
        rs.flags_nzcv = nzcv;
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // Instruction encoders
    // ------------------------------------------------------------------
    function automatic req_t raw_insn(logic [2:0] grp, logic sf, logic [1:0] op,
                                      logic [17:0] opnd, logic [4:0] rd);
        req_t rq;
        rq.req_type = grp;
        rq.size_64  = sf;
        rq.opc      = op;
        rq.operand  = opnd;
        rq.dest_reg = rd;
        return rq;
    endfunction

    function automatic req_t arith_insn(logic sf, logic [1:0] op, logic sh,
                                        logic [11:0] imm12, logic [4:0] rn,
                                        logic [4:0] rd);
        return raw_insn(GRP_ARITH, sf, op, {sh, imm12, rn}, rd);
    endfunction

    function automatic req_t move_insn(logic sf, logic [1:0] op, logic [1:0] hw,
                                       logic [15:0] imm16, logic [4:0] rd);
        return raw_insn(GRP_MOVE, sf, op, {hw, imm16}, rd);
    endfunction

    function automatic rsp_t make_rsp(logic st, logic wr, logic [4:0] rg,
                                      logic [63:0] val, logic [3:0] fl);
        rsp_t rs;
        rs.status        = st;
        rs.wrote         = wr;
        rs.written_reg   = rg;
        rs.written_value = val;
        rs.flags_nzcv    = fl;
        return rs;
    endfunction

    task automatic add_row(input req_t rq, input bit known, input rsp_t rsp);
        insn_row_t row;
        row.rq    = rq;
        row.known = known;
        row.rsp   = rsp;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Request driver: optional idle cycles, then hold the item until taken
    // ------------------------------------------------------------------
    task automatic send_insn(input req_t rq, input bit known, input rsp_t rsp);
        insn_row_t row;
        row.rq    = rq;
        row.known = known;
        row.rsp   = rsp;
        typed_results.push_back(row);
        // each cycle idles with the set percentage before the item is offered
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= rq;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    // Drop valid and hold off until every outstanding result is back
    task automatic pause_for_results();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0 || typed_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random instruction stream. Registers are drawn mostly from x0..x7 so
    // that moves build up values which later add/sub items consume; a small
    // share of items is raw noise covering the invalid groups.
    // ------------------------------------------------------------------
    task automatic run_random(input int unsigned count);
        req_t        rq;
        logic [4:0]  rd;
        logic [4:0]  rn;
        logic [11:0] imm12;
        logic [15:0] imm16;
        logic [1:0]  op;
        int unsigned pick;
        for (int unsigned k = 0; k < count; k++) begin
            rd    = ($urandom_range(7) == 0) ? 5'($urandom_range(31))
                                             : 5'($urandom_range(7));
            rn    = ($urandom_range(7) == 0) ? 5'($urandom_range(31))
                                             : 5'($urandom_range(7));
            imm12 = ($urandom_range(3) == 0) ? 12'($urandom_range(1)) : 12'($urandom);
            case ($urandom_range(5))
                0:       imm16 = 16'h0000;
                1:       imm16 = 16'hFFFF;
                2:       imm16 = 16'h8000;
                default: imm16 = 16'($urandom);
            endcase
            pick = $urandom_range(99);
            if (pick < 45) begin
                rq = arith_insn(1'($urandom_range(1)), 2'($urandom_range(3)),
                                1'($urandom_range(1)), imm12, rn, rd);
            end
            else if (pick < 88) begin
                case ($urandom_range(2))
                    0:       op = OPC_MOVN;
                    1:       op = OPC_MOVZ;
                    default: op = OPC_MOVK;
                endcase
                rq = move_insn(1'($urandom_range(1)), op, 2'($urandom_range(3)),
                               imm16, rd);
            end
            else begin
                rq = raw_insn(3'($urandom), 1'($urandom), 2'($urandom),
                              18'($urandom), 5'($urandom));
            end
            send_insn(rq, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result compare, field by field
    // ------------------------------------------------------------------
    task automatic check_result(input rsp_t want, input rsp_t got);
        if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
        end
        if (got.wrote !== want.wrote) begin
            errors++;
            $display("%0t: wrote mismatch: expected %0d, actual %0d",
                     $time, want.wrote, got.wrote);
        end
        if (got.written_reg !== want.written_reg) begin
            errors++;
            $display("%0t: written_reg mismatch: expected %0d, actual %0d",
                     $time, want.written_reg, got.written_reg);
        end
        if (got.written_value !== want.written_value) begin
            errors++;
            $display("%0t: written_value mismatch: expected %h, actual %h",
                     $time, want.written_value, got.written_value);
        end
        if (got.flags_nzcv !== want.flags_nzcv) begin
            errors++;
            $display("%0t: flags_nzcv mismatch: expected %b, actual %b",
                     $time, want.flags_nzcv, got.flags_nzcv);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge, before any of the
    // edge's updates land. Results are retired first; an item taken at this
    // edge cannot have its result out at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : scoreboard
        insn_row_t row;
        rsp_t      want;
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                results_out++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: %p",
                             $time, rsp_if.payload);
                end
                else begin
                    want = pending_results.pop_front();
                    check_result(want, rsp_if.payload);
                end
            end
            if (req_if.valid && req_if.ready) begin
                items_in++;
                if (req_if.payload.req_type == GRP_ARITH)
                    n_arith++;
                else if (req_if.payload.req_type == GRP_MOVE)
                    n_move++;
                // always advance the mirror, even when the row is hand-typed
                want = execute_insn(req_if.payload);
                if (want.status)
                    n_invalid++;
                if (want.wrote)
                    n_writes++;
                if (typed_results.size() != 0) begin
                    row = typed_results.pop_front();
                    if (row.known)
                        want = row.rsp;
                end
                pending_results.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus one long hold-off on request so the
    // block backs up and stalls its request side.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_pending) begin
                hold_left         = HOLD_CYCLES;
                long_hold_pending = 1'b0;
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else begin
                rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        for (int i = 0; i < REG_COUNT; i++)
            gpr[i] = '0;
        nzcv              = '0;
        long_hold_pending = 1'b0;
        tx_idle_pct       = 15;
        rx_idle_pct       = 86;

        // Directed table. Flags start at zero and only ADDS/SUBS move them;
        // rows with a hand-typed result track that by eye, the rest are left
        // to the mirror.
        // halfword extremes and 32-bit masking of hw 2/3
        add_row(move_insn(1'b1, OPC_MOVZ, 2'd0, 16'hFFFF, 5'd1), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd1, 64'h0000_0000_0000_FFFF, 4'b0000));
        add_row(move_insn(1'b1, OPC_MOVN, 2'd3, 16'h0000, 5'd2), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd2, 64'hFFFF_FFFF_FFFF_FFFF, 4'b0000));
        add_row(move_insn(1'b0, OPC_MOVN, 2'd2, 16'h1234, 5'd3), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd3, 64'h0000_0000_FFFF_FFFF, 4'b0000));
        add_row(move_insn(1'b0, OPC_MOVZ, 2'd3, 16'hFFFF, 5'd4), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd4, 64'h0000_0000_0000_0000, 4'b0000));
        add_row(move_insn(1'b1, OPC_MOVK, 2'd1, 16'h0000, 5'd2), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd2, 64'hFFFF_FFFF_0000_FFFF, 4'b0000));
        // invalid group and opcode
        add_row(raw_insn(3'd0, 1'b0, OPC_ADD, 18'd0, 5'd0), 1'b1,
                make_rsp(1'b1, 1'b0, 5'd0, 64'd0, 4'b0000));
        add_row(move_insn(1'b1, OPC_MOVX, 2'd0, 16'h5555, 5'd6), 1'b1,
                make_rsp(1'b1, 1'b0, 5'd0, 64'd0, 4'b0000));
        add_row(raw_insn(3'd7, 1'b1, 2'd3, 18'h3FFFF, 5'd31), 1'b1,
                make_rsp(1'b1, 1'b0, 5'd0, 64'd0, 4'b0000));
        // SP as rd or rn: skipped, flags left alone
        add_row(arith_insn(1'b1, OPC_ADDS, 1'b0, 12'd5, 5'd1, 5'd31), 1'b1,
                make_rsp(1'b0, 1'b0, 5'd0, 64'd0, 4'b0000));
        add_row(arith_insn(1'b1, OPC_SUBS, 1'b1, 12'hFFF, 5'd31, 5'd5), 1'b1,
                make_rsp(1'b0, 1'b0, 5'd0, 64'd0, 4'b0000));
        // XZR target for wide moves: computed, then dropped
        add_row(move_insn(1'b1, OPC_MOVZ, 2'd0, 16'hFFFF, 5'd31), 1'b1,
                make_rsp(1'b0, 1'b0, 5'd0, 64'd0, 4'b0000));
        add_row(move_insn(1'b1, OPC_MOVK, 2'd2, 16'h0005, 5'd31), 1'b1,
                make_rsp(1'b0, 1'b0, 5'd0, 64'd0, 4'b0000));
        // 64-bit carry and zero, then borrow and negative
        add_row(move_insn(1'b1, OPC_MOVN, 2'd0, 16'h0000, 5'd8), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd8, 64'hFFFF_FFFF_FFFF_FFFF, 4'b0000));
        add_row(arith_insn(1'b1, OPC_ADDS, 1'b0, 12'd1, 5'd8, 5'd9), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd9, 64'd0, 4'b0110));
        add_row(arith_insn(1'b1, OPC_SUBS, 1'b0, 12'd1, 5'd9, 5'd10), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd10, 64'hFFFF_FFFF_FFFF_FFFF, 4'b1000));
        // 32-bit carry and zero from x3 = 0xFFFFFFFF
        add_row(arith_insn(1'b0, OPC_ADDS, 1'b0, 12'd1, 5'd3, 5'd11), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd11, 64'd0, 4'b0110));
        // signed overflow at 64 bits
        add_row(move_insn(1'b1, OPC_MOVN, 2'd3, 16'h8000, 5'd13), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd13, 64'h7FFF_FFFF_FFFF_FFFF, 4'b0110));
        add_row(arith_insn(1'b1, OPC_ADDS, 1'b0, 12'd1, 5'd13, 5'd14), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd14, 64'h8000_0000_0000_0000, 4'b1001));
        // signed overflow at 32 bits, both directions
        add_row(move_insn(1'b0, OPC_MOVN, 2'd1, 16'h8000, 5'd15), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd15, 64'h0000_0000_7FFF_FFFF, 4'b1001));
        add_row(arith_insn(1'b0, OPC_ADDS, 1'b0, 12'd1, 5'd15, 5'd16), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd16, 64'h0000_0000_8000_0000, 4'b1001));
        add_row(arith_insn(1'b0, OPC_SUBS, 1'b0, 12'd1, 5'd16, 5'd17), 1'b1,
                make_rsp(1'b0, 1'b1, 5'd17, 64'h0000_0000_7FFF_FFFF, 4'b0011));
        // shifted immediate, plain ADD/SUB, MOVK hw 3 at 32 bits
        add_row(arith_insn(1'b0, OPC_SUBS, 1'b1, 12'hFFF, 5'd11, 5'd12), 1'b0, '0);
        add_row(arith_insn(1'b1, OPC_ADD, 1'b1, 12'hFFF, 5'd2, 5'd18), 1'b0, '0);
        add_row(arith_insn(1'b0, OPC_SUB, 1'b0, 12'hFFF, 5'd1, 5'd19), 1'b0, '0);
        add_row(move_insn(1'b0, OPC_MOVK, 2'd3, 16'hABCD, 5'd2), 1'b0, '0);

        // hold reset, then release it on an edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: sender mostly busy, receiver mostly stalled
        foreach (directed_rows[k])
            send_insn(directed_rows[k].rq, directed_rows[k].known, directed_rows[k].rsp);
        run_random(225);
        pause_for_results();

        // phase 2: roles swapped
        tx_idle_pct = 86;
        rx_idle_pct = 15;
        run_random(225);
        pause_for_results();

        // phase 3: full rate both ways, opened by a long receiver hold-off
        // while the sender keeps offering items
        tx_idle_pct       = 0;
        rx_idle_pct       = 0;
        long_hold_pending = 1'b1;
        run_random(230);
        pause_for_results();

        $display("Ran %0d items (%0d add/sub, %0d wide move, %0d invalid status)",
                 items_in, n_arith, n_move, n_invalid);
        $display("Checked %0d results, %0d register writes, %0d mismatches",
                 results_out, n_writes, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== aarch64_immediate_alu.f =====
design/aai_pkg.sv
design/aai_stream_if.sv
design/aarch64_immediate_alu.sv
tb/sv/tb_aarch64_immediate_alu.sv
